@@ rtl/fbpa_pkg.sv @@
// ----------------------------------------------------------------------------
// fbpa_pkg
// Shared constants for the fixed block pool allocator: sizes, codes, indexes.
// ----------------------------------------------------------------------------
package fbpa_pkg;

  // pool geometry
  localparam int MAX_BLOCKS  = 256;
  localparam int RING_AW     = $clog2(MAX_BLOCKS);
  localparam int COUNT_W     = RING_AW + 1;
  localparam int NODE_SIZE   = 8;
  localparam int ALIGN_BYTES = 4;

  // request actions
  localparam logic [1:0] ACT_GET  = 2'd0;
  localparam logic [1:0] ACT_PUT  = 2'd1;
  localparam logic [1:0] ACT_INIT = 2'd2;

  // result status codes
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_EMPTY     = 3'd1;
  localparam logic [2:0] ST_BAD_ADDR  = 3'd2;
  localparam logic [2:0] ST_BAD_BLOCK = 3'd3;
  localparam logic [2:0] ST_BAD_POOL  = 3'd4;
  localparam logic [2:0] ST_BAD_BASE  = 3'd5;
  localparam logic [2:0] ST_OVERFLOW  = 3'd6;

  // configuration register indexes
  localparam logic [1:0] REG_BASE  = 2'd0;
  localparam logic [1:0] REG_POOL  = 2'd1;
  localparam logic [1:0] REG_BLOCK = 2'd2;
  localparam logic [1:0] REG_CHECK = 2'd3;

endpackage

@@ rtl/fixed_block_pool_allocator.sv @@
// ----------------------------------------------------------------------------
// fixed_block_pool_allocator
// Pool of equal-sized memory blocks kept as a ring of free block addresses.
// ----------------------------------------------------------------------------
// Usage:
//   Requests arrive on the in_ stream: in_tuser carries the action (get, put,
//   init) and in_tdata the block address for a put. Each request yields one
//   result on the out_ stream: out_tuser carries the status, out_tdata the
//   granted address and the free block count after the request.
//   Registers (base, pool size, block size, check enable) sit on the cfg_ APB
//   port; the user is to write them only while the block is idle, the block
//   itself does not enforce this. The block takes one request at a time and
//   drops in_tready until the result has been moved into the output register.
//   A get makes one ring read through the registered RAM port. An init runs
//   32 restoring divide steps and then one ring write per block, all through
//   a single shared 33-bit adder.
//   After reset the ring is empty (count 0, head 0) and check_enable is 1;
//   the ring RAM itself is not cleared, its entries are written by init/put.
//   If out_tready is low the result waits in the output register; the next
//   request is taken meanwhile and its result waits until that one leaves.
// ----------------------------------------------------------------------------
module fixed_block_pool_allocator
  import fbpa_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // request stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] block_addr
  input  logic [1:0]  in_tuser,   // [1:0] action
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // [31:0] granted_addr, [40:32] free_blocks, rest 0
  output logic [2:0]  out_tuser,  // [2:0] status
  // configuration port
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  // sequencer states
  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_GET    = 3'd1;
  localparam logic [2:0] S_DIV    = 3'd2;
  localparam logic [2:0] S_DIVEND = 3'd3;
  localparam logic [2:0] S_FILL   = 3'd4;
  localparam logic [2:0] S_RESP   = 3'd5;

  // configuration registers
  logic [31:0] base_r;
  logic [31:0] pool_r;
  logic [15:0] bsize_r;
  logic        check_r;

  // sequencer and pool state
  logic [2:0]         state_r, state_nxt;
  logic [RING_AW-1:0] head_r, head_nxt;
  logic [COUNT_W-1:0] count_r, count_nxt;
  logic [2:0]         res_status_r, res_status_nxt;
  logic [31:0]        res_addr_r, res_addr_nxt;

  // divider / fill working registers
  logic [15:0]        rem_r, rem_nxt;
  logic [31:0]        quo_r, quo_nxt;
  logic [4:0]         step_r, step_nxt;
  logic [31:0]        fill_addr_r, fill_addr_nxt;
  logic [RING_AW-1:0] fill_idx_r, fill_idx_nxt;

  // output register
  logic        out_valid_r;
  logic [2:0]  out_status_r;
  logic [31:0] out_addr_r;
  logic [COUNT_W-1:0] out_free_r;

  // shared adder
  logic [32:0] op_a, op_b, sum;
  logic        cin;

  // ring memory ports
  logic               ram_we;
  logic [RING_AW-1:0] ram_waddr;
  logic [31:0]        ram_wdata;
  logic [31:0]        ram_rdata;

  logic        in_fire;
  logic        cfg_wr;
  logic [16:0] rem_shift;
  logic        cfg_bad_base, cfg_bad_block, cfg_bad_pool;

  assign in_tready  = (state_r == S_IDLE);
  assign in_fire    = in_tvalid && in_tready;
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r  <= '0;
      pool_r  <= '0;
      bsize_r <= '0;
      check_r <= 1'b1;
    end else if (cfg_wr) begin
      case (cfg_paddr[3:2])
        REG_BASE:  base_r  <= cfg_pwdata;
        REG_POOL:  pool_r  <= cfg_pwdata;
        REG_BLOCK: bsize_r <= cfg_pwdata[15:0];
        REG_CHECK: check_r <= cfg_pwdata[0];
        default:   ;
      endcase
    end
  end

  // configuration reads
  always_comb begin
    case (cfg_paddr[3:2])
      REG_BASE:  cfg_prdata = base_r;
      REG_POOL:  cfg_prdata = pool_r;
      REG_BLOCK: cfg_prdata = {16'd0, bsize_r};
      REG_CHECK: cfg_prdata = {31'd0, check_r};
      default:   cfg_prdata = '0;
    endcase
  end

  // init parameter checks
  assign cfg_bad_base  = (base_r == 32'd0);
  assign cfg_bad_block = (bsize_r < 16'(NODE_SIZE)) || ((bsize_r % 16'(ALIGN_BYTES)) != 16'd0);
  assign cfg_bad_pool  = (pool_r < {16'd0, bsize_r}) ||
                         ((pool_r % 32'(ALIGN_BYTES)) != 32'd0);

  // shared adder: trial subtract while dividing, address step while filling
  assign rem_shift = {rem_r, quo_r[31]};
  always_comb begin
    if (state_r == S_FILL) begin
      op_a = {1'b0, fill_addr_r};
      op_b = {17'd0, bsize_r};
      cin  = 1'b0;
    end else begin
      op_a = {16'd0, rem_shift};
      op_b = ~{17'd0, bsize_r};
      cin  = 1'b1;
    end
  end
  assign sum = op_a + op_b + {32'd0, cin};

  // ring memory
  fbpa_ram #(
    .WIDTH (32),
    .DEPTH (MAX_BLOCKS)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (head_r),
    .rdata (ram_rdata)
  );

  // sequencer
  always_comb begin
    state_nxt      = state_r;
    head_nxt       = head_r;
    count_nxt      = count_r;
    res_status_nxt = res_status_r;
    res_addr_nxt   = res_addr_r;
    rem_nxt        = rem_r;
    quo_nxt        = quo_r;
    step_nxt       = step_r;
    fill_addr_nxt  = fill_addr_r;
    fill_idx_nxt   = fill_idx_r;
    ram_we         = 1'b0;
    ram_waddr      = head_r + count_r[RING_AW-1:0];
    ram_wdata      = in_tdata;

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          res_status_nxt = ST_OK;
          res_addr_nxt   = '0;
          state_nxt      = S_RESP;
          case (in_tuser)
            ACT_GET: begin
              if (count_r == '0) begin
                res_status_nxt = ST_EMPTY;
              end else begin
                state_nxt = S_GET;
              end
            end
            ACT_PUT: begin
              if (check_r && in_tdata == 32'd0) begin
                res_status_nxt = ST_BAD_ADDR;
              end else if (count_r == COUNT_W'(MAX_BLOCKS)) begin
                res_status_nxt = ST_OVERFLOW;
              end else begin
                ram_we    = 1'b1;
                count_nxt = count_r + 1'b1;
              end
            end
            ACT_INIT: begin
              if (check_r && cfg_bad_base) begin
                res_status_nxt = ST_BAD_BASE;
              end else if (check_r && cfg_bad_block) begin
                res_status_nxt = ST_BAD_BLOCK;
              end else if (check_r && cfg_bad_pool) begin
                res_status_nxt = ST_BAD_POOL;
              end else if (bsize_r == 16'd0) begin
                res_status_nxt = ST_BAD_BLOCK;
              end else begin
                rem_nxt   = '0;
                quo_nxt   = pool_r;
                step_nxt  = '0;
                state_nxt = S_DIV;
              end
            end
            default: ;
          endcase
        end
      end

      // head entry was read at the request edge
      S_GET: begin
        res_addr_nxt = ram_rdata;
        head_nxt     = head_r + 1'b1;
        count_nxt    = count_r - 1'b1;
        state_nxt    = S_RESP;
      end

      // one restoring divide step per cycle
      S_DIV: begin
        if (!sum[32]) begin
          rem_nxt = sum[15:0];
          quo_nxt = {quo_r[30:0], 1'b1};
        end else begin
          rem_nxt = rem_shift[15:0];
          quo_nxt = {quo_r[30:0], 1'b0};
        end
        step_nxt = step_r + 1'b1;
        if (step_r == 5'd31) begin
          state_nxt = S_DIVEND;
        end
      end

      // block count known: reject, finish empty, or start the fill
      S_DIVEND: begin
        fill_addr_nxt = base_r;
        fill_idx_nxt  = quo_r[RING_AW-1:0] - 1'b1;
        if (quo_r > 32'(MAX_BLOCKS)) begin
          res_status_nxt = ST_BAD_POOL;
          state_nxt      = S_RESP;
        end else if (quo_r == 32'd0) begin
          head_nxt  = '0;
          count_nxt = '0;
          state_nxt = S_RESP;
        end else begin
          state_nxt = S_FILL;
        end
      end

      // lowest block goes to the last entry, walking down to entry zero
      S_FILL: begin
        ram_we        = 1'b1;
        ram_waddr     = fill_idx_r;
        ram_wdata     = fill_addr_r;
        fill_addr_nxt = sum[31:0];
        fill_idx_nxt  = fill_idx_r - 1'b1;
        if (fill_idx_r == '0) begin
          head_nxt  = '0;
          count_nxt = quo_r[COUNT_W-1:0];
          state_nxt = S_RESP;
        end
      end

      // hand the result to the output register once it is free
      S_RESP: begin
        if (!out_valid_r || out_tready) begin
          state_nxt = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      head_r  <= '0;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      head_r  <= head_nxt;
      count_r <= count_nxt;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    res_status_r <= res_status_nxt;
    res_addr_r   <= res_addr_nxt;
    rem_r        <= rem_nxt;
    quo_r        <= quo_nxt;
    step_r       <= step_nxt;
    fill_addr_r  <= fill_addr_nxt;
    fill_idx_r   <= fill_idx_nxt;
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == S_RESP && (!out_valid_r || out_tready)) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_RESP && (!out_valid_r || out_tready)) begin
      out_status_r <= res_status_r;
      out_addr_r   <= res_addr_r;
      out_free_r   <= count_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = {7'd0, out_free_r, out_addr_r};

endmodule

@@ rtl/fbpa_ram.sv @@
// ----------------------------------------------------------------------------
// fbpa_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module fbpa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule
